@@ rtl/udiv64_pkg.sv @@
// Shared types and constants of the 64-bit unsigned divider.
`default_nettype none

package udiv64_pkg;

    // Width of the operand and quotient fields on the ports.
    localparam int FIELD_W = 64;

    // Default working width of the division.
    localparam int DATA_WIDTH_DEF = 64;

    typedef struct packed {
        logic [FIELD_W-1:0] dividend;
        logic [FIELD_W-1:0] divisor;
    } t_udiv64_in;

    typedef struct packed {
        logic [FIELD_W-1:0] quotient;
        logic               divide_by_zero;
    } t_udiv64_out;

    // Sequencer commands to the datapath and the output register.
    typedef struct packed {
        logic load;    // capture a new word into the shift registers
        logic step;    // retire one quotient bit
        logic finish;  // hand the quotient to the output register
    } t_udiv64_ctl;

endpackage

`default_nettype wire

@@ rtl/udiv64_ctrl.sv @@
// Sequencer of the divider: bit counter and run state.
`default_nettype none

module udiv64_ctrl
    import udiv64_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire logic  i_out_free,
    output logic       o_in_stall,
    output t_udiv64_ctl o_ctl
);

    localparam int CNT_W = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_ctl        = '0;
        o_in_stall   = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_cnt      = CNT_LAST;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                o_ctl.step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_DONE: begin
                // hold the quotient until the output register can take it
                if (i_out_free) begin
                    o_ctl.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

@@ rtl/udiv64_dp.sv @@
// Shift-and-subtract datapath of the divider, one quotient bit per step.
`default_nettype none

module udiv64_dp
    import udiv64_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire t_udiv64_ctl i_ctl,
    input  wire t_udiv64_in  i_in_data,
    output t_udiv64_out      o_result
);

    logic [DATA_WIDTH-1:0] r_rem, n_rem;
    logic [DATA_WIDTH-1:0] r_num, n_num;   // dividend shifts out, quotient shifts in
    logic [DATA_WIDTH-1:0] r_den, n_den;
    logic                  r_dz, n_dz;

    logic [DATA_WIDTH:0]   w_trial;
    logic [DATA_WIDTH:0]   w_diff;

    assign w_trial = {r_rem, r_num[DATA_WIDTH-1]};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_comb begin
        n_rem = r_rem;
        n_num = r_num;
        n_den = r_den;
        n_dz  = r_dz;
        if (i_ctl.load) begin
            n_rem = '0;
            n_num = i_in_data.dividend[DATA_WIDTH-1:0];
            n_den = i_in_data.divisor[DATA_WIDTH-1:0];
            n_dz  = (i_in_data.divisor[DATA_WIDTH-1:0] == '0);
        end else if (i_ctl.step) begin
            // keep the difference when no borrow, else restore
            if (!w_diff[DATA_WIDTH]) begin
                n_rem = w_diff[DATA_WIDTH-1:0];
            end else begin
                n_rem = w_trial[DATA_WIDTH-1:0];
            end
            n_num = {r_num[DATA_WIDTH-2:0], ~w_diff[DATA_WIDTH]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_num <= n_num;
        r_den <= n_den;
        r_dz  <= n_dz;
    end

    // A zero divisor never borrows, so the quotient comes out all ones.
    assign o_result.quotient       = FIELD_W'(r_num);
    assign o_result.divide_by_zero = r_dz;

endmodule

`default_nettype wire

@@ rtl/unsigned_divider_64.sv @@
// Top level of the 64-bit unsigned divider.
//
// Divides an unsigned dividend by an unsigned divisor and returns the exact
// truncated quotient. A word is accepted when i_in_valid is high and
// o_in_stall is low; the result word is taken when o_out_valid is high and
// i_out_stall is low. The low DATA_WIDTH bits of each operand are used and
// the quotient is zero-extended to 64 bits. A zero divisor returns all ones
// within DATA_WIDTH with divide_by_zero set; a zero dividend returns zero.
// The core is a restoring shift-and-subtract divider that retires one
// quotient bit per cycle through a (DATA_WIDTH+1)-bit subtractor. A word
// passes through capture, DATA_WIDTH steps and a hand-off that waits for
// a free output register. The result sits in that output register, so
// the next word is taken while an earlier result still waits downstream.
`default_nettype none

module unsigned_divider_64
    import udiv64_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_udiv64_in i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_udiv64_out     o_out_data
);

    t_udiv64_ctl w_ctl;
    t_udiv64_out w_result;
    logic        w_out_free;

    logic        r_out_valid, n_out_valid;
    t_udiv64_out r_out_data, n_out_data;

    // The output register is free when empty or being drained this cycle.
    assign w_out_free = !r_out_valid || !i_out_stall;

    udiv64_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (w_out_free),
        .o_in_stall (o_in_stall),
        .o_ctl      (w_ctl)
    );

    udiv64_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_in_data (i_in_data),
        .o_result  (w_result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (w_ctl.finish) begin
            // load the new quotient; the old word, if any, leaves now
            n_out_valid = 1'b1;
            n_out_data  = w_result;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

@@ rtl/udiv64_chk.sv @@
// Port-level checker of the divider and its bind to the top level.
`default_nettype none

module udiv64_chk
    import udiv64_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire t_udiv64_out o_out_data
);

    localparam logic [FIELD_W-1:0] Q_MASK =
        FIELD_W'(((FIELD_W+1)'(1) << DATA_WIDTH) - (FIELD_W+1)'(1));

    // Hold a stalled result word.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result word changed or dropped");

    // Stall the input while a word is being divided.
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a division runs");

    // A fresh result frees the core for the next word.
    a_rise_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("core still busy when its result appeared");

    // A zero-divisor result is all ones within the working width.
    a_dz_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.divide_by_zero) |-> (o_out_data.quotient == Q_MASK))
        else $error("zero divisor without all-ones quotient");

endmodule

bind unsigned_divider_64 udiv64_chk #(
    .DATA_WIDTH (DATA_WIDTH)
) u_udiv64_chk (.*);

`default_nettype wire

@@ verif/unsigned_divider_64_tb.sv @@
// Self-checking testbench for the 64-bit unsigned divider.
`timescale 1ns / 1ps

module unsigned_divider_64_tb;
    import udiv64_pkg::*;

    localparam int          WIDTH       = DATA_WIDTH_DEF;
    localparam int          CLK_HALF    = 5;
    localparam int          RESET_LEN   = 10;
    // Settle time after the drain, sized to two passes of a word through the core.
    localparam int          SETTLE_LEN  = 2 * (WIDTH + 2);
    localparam int          HOLD_LEN    = 600;
    localparam int          RANDOM_LEN  = 135;
    localparam logic [63:0] ALL_ONES    = '1;
    localparam logic [63:0] TOP_BIT     = 64'h8000_0000_0000_0000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_udiv64_in  in_data = '0;
    logic        out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_udiv64_out o_out_data;

    // Quotient words still owed by the block, oldest first.
    t_udiv64_out expected_quotients[$];
    int          error_count = 0;

    // Idle odds in percent, changed per test phase.
    int          send_idle_pct = 0;
    int          stall_pct = 0;

    // Long receiver hold-off: bump the request, the receiver counts it down.
    int          hold_request = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    always #CLK_HALF i_clk = ~i_clk;

    unsigned_divider_64 u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    // Expected result of one word: truncated quotient, or all ones plus the
    // flag when the divisor is zero. Only the low WIDTH bits take part.
    function automatic t_udiv64_out divide_word(input t_udiv64_in w);
        logic [63:0] mask;
        logic [63:0] num;
        logic [63:0] den;
        t_udiv64_out r;
        mask = (WIDTH >= 64) ? ALL_ONES : ((64'd1 << WIDTH) - 64'd1);
        num  = w.dividend & mask;
        den  = w.divisor & mask;
        if (den == '0) begin
            r.quotient       = mask;
            r.divide_by_zero = 1'b1;
        end else begin
            r.quotient       = (num / den) & mask;
            r.divide_by_zero = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Random operand: full width half of the time, otherwise shortened so
    // quotients spread over all sizes, with zero and all ones mixed in.
    function automatic logic [63:0] random_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       v = '0;
            1:       v = ALL_ONES;
            2, 3, 4: v = v >> $urandom_range(63);
            default: ;
        endcase
        return v;
    endfunction

    // Offer one word, idling first at the current odds, and hold it until taken.
    // Valid only changes at falling edges; acceptance is seen at the rising edge.
    task automatic push_word(input logic [63:0] dividend, input logic [63:0] divisor);
        t_udiv64_in w;
        w.dividend = dividend;
        w.divisor  = divisor;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_quotients.insert(expected_quotients.size(), divide_word(w));
    endtask

    task automatic go_quiet();
        @(negedge i_clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_results_in();
        while (expected_quotients.size() != 0) @(posedge i_clk);
    endtask

    task automatic push_random_words(input int count);
        logic [63:0] divisor;
        for (int i = 0; i < count; i++) begin
            divisor = random_operand();
            // Bias toward small divisors so quotients are long.
            if ($urandom_range(1)) divisor = divisor >> $urandom_range(63);
            push_word(random_operand(), divisor);
        end
    endtask

    // Receiver: drive stall at the falling edge, either from a pending
    // hold-off or at random at the current odds.
    always @(negedge i_clk) begin
        if (hold_request != hold_seen) begin
            hold_seen = hold_request;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Checker: compare every accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_udiv64_out want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_quotients.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: quotient %h flag %b",
                    o_out_data.quotient, o_out_data.divide_by_zero));
            end else begin
                want = expected_quotients.pop_front();
                if (o_out_data.quotient !== want.quotient)
                    report_mismatch($sformatf("quotient %h, expected %h",
                        o_out_data.quotient, want.quotient));
                if (o_out_data.divide_by_zero !== want.divide_by_zero)
                    report_mismatch($sformatf("divide_by_zero %b, expected %b",
                        o_out_data.divide_by_zero, want.divide_by_zero));
            end
        end
    end

    // Extremes and special cases, no idling on either side.
    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        // zero divisor, with zero and nonzero dividends
        push_word('0, '0);
        push_word(ALL_ONES, '0);
        push_word(64'h0123_4567_89AB_CDEF, '0);
        // zero dividend, nonzero divisor
        push_word('0, 64'd1);
        push_word('0, ALL_ONES);
        // divide by one and by itself
        push_word(ALL_ONES, 64'd1);
        push_word(64'd1, 64'd1);
        push_word(ALL_ONES, ALL_ONES);
        push_word(64'd12345, 64'd12345);
        // dividend below divisor gives zero
        push_word(ALL_ONES - 64'd1, ALL_ONES);
        push_word(64'd1, ALL_ONES);
        push_word(TOP_BIT - 64'd1, TOP_BIT);
        // long and short quotients
        push_word(ALL_ONES, 64'd2);
        push_word(ALL_ONES, 64'd3);
        push_word(TOP_BIT, 64'd1);
        push_word(TOP_BIT, TOP_BIT - 64'd1);
        push_word(ALL_ONES, 64'h1_0000_0000);
        push_word(64'h1_0000_0000, 64'h1_0000_0001);
        push_word(64'd5, 64'd3);
        // alternating bit patterns and split halves
        push_word(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        push_word(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        push_word(64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF);
    endtask

    task automatic test_steady_stream();
        send_idle_pct = 0;
        stall_pct     = 0;
        push_random_words(RANDOM_LEN);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct = 51;
        stall_pct     = 0;
        push_random_words(RANDOM_LEN);
    endtask

    task automatic test_receiver_stalls();
        send_idle_pct = 0;
        stall_pct     = 51;
        push_random_words(RANDOM_LEN);
    endtask

    task automatic test_mixed_idle();
        send_idle_pct = 25;
        stall_pct     = 25;
        push_random_words(RANDOM_LEN);
    endtask

    // Hold the receiver off for a long stretch while words keep coming, so the
    // output register and the core fill and the input side stalls.
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        @(posedge i_clk);
        hold_request++;
        push_random_words(16);
    endtask

    // Stop sending until every owed result is in, then resume.
    task automatic test_pause();
        send_idle_pct = 10;
        stall_pct     = 30;
        push_random_words(20);
        go_quiet();
        wait_results_in();
        push_random_words(20);
    endtask

    initial begin
        repeat (RESET_LEN) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_steady_stream();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idle();
        test_backpressure();
        test_pause();

        // Drain, then watch a while longer for stray results.
        go_quiet();
        wait_results_in();
        repeat (SETTLE_LEN) @(posedge i_clk);
        if (expected_quotients.size() != 0)
            report_mismatch($sformatf("%0d results never came",
                expected_quotients.size()));

        if (error_count == 0) begin
            $display("** unsigned_divider_64: PASSED **");
        end else begin
            $display("** unsigned_divider_64: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5ms;
        $display("ERROR: timeout with %0d results pending", expected_quotients.size());
        $display("** unsigned_divider_64: FAILED **");
        $finish;
    end

endmodule

@@ unsigned_divider_64.f @@
rtl/udiv64_pkg.sv
rtl/udiv64_ctrl.sv
rtl/udiv64_dp.sv
rtl/unsigned_divider_64.sv
rtl/udiv64_chk.sv
verif/unsigned_divider_64_tb.sv
